[rtl/bayer_demosaic_5x5_defines.svh]
// Assertion macros shared by the demosaic RTL.
`ifndef BAYER_DEMOSAIC_5X5_DEFINES_SVH
`define BAYER_DEMOSAIC_5X5_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BDM_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define BDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bdm_pkg.sv]
// Shared types and constants of the Bayer demosaic block.
package bdm_pkg;

    // Configuration port
    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MAX_HEIGHT   = 2048;
    localparam int ROW_BITS     = 12;

    // Line stores and window
    localparam int LINE_BANKS = 4;
    localparam int WIN_SIZE   = 5;

    // Window taps carried from front to back end
    localparam int NUM_TAPS = 13;
    localparam int TAP_C    = 0;
    localparam int TAP_N1   = 1;
    localparam int TAP_S1   = 2;
    localparam int TAP_W1   = 3;
    localparam int TAP_E1   = 4;
    localparam int TAP_N2   = 5;
    localparam int TAP_S2   = 6;
    localparam int TAP_W2   = 7;
    localparam int TAP_E2   = 8;
    localparam int TAP_NW   = 9;
    localparam int TAP_NE   = 10;
    localparam int TAP_SW   = 11;
    localparam int TAP_SE   = 12;

    // Queue depths
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 4;

    // Site class and framing marks of one interior pixel
    typedef struct packed {
        logic odd_row;
        logic odd_col;
        logic end_of_row;
        logic end_of_frame;
    } bdm_tag_t;

endpackage

[rtl/bdm_fifo.sv]
// Small register queue with occupancy count.
`include "bayer_demosaic_5x5_defines.svh"

module bdm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;

    // Write the tail entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wptr_reg] <= wdata;
        end
    end

    // Track occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign rdata = store_reg[rptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    `BDM_ASSERT(a_no_overflow, !(push && count_reg == CNTW'(DEPTH)), "push into a full queue")
    `BDM_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")
    `BDM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule

[rtl/bdm_front.sv]
// Front end: raster counters, line stores, 5x5 window and site classification.
module bdm_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [bdm_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [bdm_pkg::CFG_BITS-1:0]               cfg_data,
    input  logic                                       accept,
    input  logic [PIXEL_BITS-1:0]                      raw_pixel,
    output logic                                       task_valid,
    output logic [bdm_pkg::NUM_TAPS*PIXEL_BITS-1:0]    task_taps,
    output bdm_pkg::bdm_tag_t                          task_tag,
    output logic [1:0]                                 in_flight
);

    import bdm_pkg::*;

    localparam int LINE_LEN = MAX_WIDTH + 4;
    localparam int CW       = $clog2(LINE_LEN);
    localparam int EW       = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int W_RESET  = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;

    logic [CW-1:0]       last_col_reg;
    logic [ROW_BITS-1:0] last_row_reg;
    logic [CW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_next;

    logic [EW-1:0]       w_ext;
    logic [EW-1:0]       w_eff;
    logic [ROW_BITS-1:0] h_ext;
    logic [ROW_BITS-1:0] h_eff;
    logic                cfg_hit;

    logic                interior0;
    bdm_tag_t            tag0;

    logic                s1_valid_reg;
    logic                s1_interior_reg;
    bdm_tag_t            s1_tag_reg;
    logic [1:0]          s1_bank_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;

    logic                s2_valid_reg;
    logic                s2_interior_reg;
    bdm_tag_t            s2_tag_reg;

    logic [PIXEL_BITS-1:0] bank_rd [LINE_BANKS];
    logic [PIXEL_BITS-1:0] win_col [WIN_SIZE];
    logic [PIXEL_BITS-1:0] win_reg [WIN_SIZE][WIN_SIZE];

    // Clamp written sizes into the supported range
    always_comb
    begin
        w_ext = EW'(cfg_data);
        if (w_ext == '0)
        begin
            w_eff = EW'(1);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end

        h_ext = ROW_BITS'(cfg_data);
        if (h_ext == '0)
        begin
            h_eff = ROW_BITS'(1);
        end
        else if (h_ext > ROW_BITS'(MAX_HEIGHT))
        begin
            h_eff = ROW_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end
    end

    assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // Hold last padded column and row indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= CW'(W_RESET + 3);
            last_row_reg <= ROW_BITS'(HEIGHT_RESET + 3);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                last_col_reg <= CW'(w_eff) + CW'(3);
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                last_row_reg <= h_eff + ROW_BITS'(3);
            end
        end
    end

    // Step the raster position
    always_comb
    begin
        if (col_reg == last_col_reg)
        begin
            col_next = '0;
            row_next = (row_reg == last_row_reg) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Classify the request by position
    always_comb
    begin
        interior0         = (row_reg >= ROW_BITS'(4)) && (col_reg >= CW'(4));
        tag0.odd_row      = row_reg[0];
        tag0.odd_col      = col_reg[0];
        tag0.end_of_row   = (col_reg == last_col_reg);
        tag0.end_of_frame = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    end

    // Line stores: one bank per row modulo four, read before write
    for (genvar b = 0; b < LINE_BANKS; b++)
    begin : g_bank
        logic [PIXEL_BITS-1:0] line_mem [LINE_LEN];

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (row_reg[1:0] == 2'(b))
                begin
                    line_mem[col_reg] <= raw_pixel;
                end
                bank_rd[b] <= line_mem[col_reg];
            end
        end
    end

    // Stage 1 and stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_interior_reg <= interior0;
            s1_tag_reg      <= tag0;
            s1_bank_reg     <= row_reg[1:0];
            s1_pixel_reg    <= raw_pixel;
        end
        if (s1_valid_reg)
        begin
            s2_interior_reg <= s1_interior_reg;
            s2_tag_reg      <= s1_tag_reg;
        end
    end

    // Order line store outputs from oldest row to newest
    always_comb
    begin
        for (int k = 0; k < LINE_BANKS; k++)
        begin
            win_col[k] = bank_rd[s1_bank_reg + 2'(k)];
        end
        win_col[WIN_SIZE-1] = s1_pixel_reg;
    end

    // Shift the window one column left
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int y = 0; y < WIN_SIZE; y++)
            begin
                for (int x = 0; x < WIN_SIZE - 1; x++)
                begin
                    win_reg[y][x] <= win_reg[y][x+1];
                end
                win_reg[y][WIN_SIZE-1] <= win_col[y];
            end
        end
    end

    // Hand interior requests to the back end
    always_comb
    begin
        task_taps = '0;
        task_taps[TAP_C*PIXEL_BITS  +: PIXEL_BITS] = win_reg[2][2];
        task_taps[TAP_N1*PIXEL_BITS +: PIXEL_BITS] = win_reg[1][2];
        task_taps[TAP_S1*PIXEL_BITS +: PIXEL_BITS] = win_reg[3][2];
        task_taps[TAP_W1*PIXEL_BITS +: PIXEL_BITS] = win_reg[2][1];
        task_taps[TAP_E1*PIXEL_BITS +: PIXEL_BITS] = win_reg[2][3];
        task_taps[TAP_N2*PIXEL_BITS +: PIXEL_BITS] = win_reg[0][2];
        task_taps[TAP_S2*PIXEL_BITS +: PIXEL_BITS] = win_reg[4][2];
        task_taps[TAP_W2*PIXEL_BITS +: PIXEL_BITS] = win_reg[2][0];
        task_taps[TAP_E2*PIXEL_BITS +: PIXEL_BITS] = win_reg[2][4];
        task_taps[TAP_NW*PIXEL_BITS +: PIXEL_BITS] = win_reg[1][1];
        task_taps[TAP_NE*PIXEL_BITS +: PIXEL_BITS] = win_reg[1][3];
        task_taps[TAP_SW*PIXEL_BITS +: PIXEL_BITS] = win_reg[3][1];
        task_taps[TAP_SE*PIXEL_BITS +: PIXEL_BITS] = win_reg[3][3];
    end

    assign task_valid = s2_valid_reg && s2_interior_reg;
    assign task_tag   = s2_tag_reg;
    assign in_flight  = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

[rtl/bdm_back.sv]
// Back end: Malvar-He-Cutler kernel sums, scaling, saturation and colour selection.
module bdm_back #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  logic [bdm_pkg::NUM_TAPS*PIXEL_BITS-1:0]    taps,
    input  bdm_pkg::bdm_tag_t                          tag,
    output logic                                       res_valid,
    output logic [PIXEL_BITS-1:0]                      red,
    output logic [PIXEL_BITS-1:0]                      green,
    output logic [PIXEL_BITS-1:0]                      blue,
    output logic                                       end_of_row,
    output logic                                       end_of_frame,
    output logic                                       busy
);

    import bdm_pkg::*;

    // Sums span -12 to +28 times the full-scale sample
    localparam int SW = PIXEL_BITS + 6;

    logic signed [SW-1:0] c, n1, s1, w1, e1, n2, s2, w2, e2, nw, ne, sw, se;
    logic signed [SW-1:0] g_rb_sum, horiz_sum, vert_sum, diag_sum;

    logic                  a_valid_reg;
    logic signed [SW-1:0]  g_rb_reg;
    logic signed [SW-1:0]  horiz_reg;
    logic signed [SW-1:0]  vert_reg;
    logic signed [SW-1:0]  diag_reg;
    logic [PIXEL_BITS-1:0] centre_reg;
    bdm_tag_t              tag_reg;

    logic [PIXEL_BITS-1:0] g_rb_px, horiz_px, vert_px, diag_px;

    function automatic logic signed [SW-1:0] tap(input logic [NUM_TAPS*PIXEL_BITS-1:0] t,
                                                 input int idx);
        return signed'(SW'(t[idx*PIXEL_BITS +: PIXEL_BITS]));
    endfunction

    // Divide by 16 with floor, then saturate to the pixel range
    function automatic logic [PIXEL_BITS-1:0] finish(input logic signed [SW-1:0] s);
        logic [PIXEL_BITS-1:0] q;
        if (s[SW-1])
        begin
            q = '0;
        end
        else if (s[PIXEL_BITS+4])
        begin
            q = '1;
        end
        else
        begin
            q = s[PIXEL_BITS+3:4];
        end
        return q;
    endfunction

    // Unpack taps
    always_comb
    begin
        c  = tap(taps, TAP_C);
        n1 = tap(taps, TAP_N1);
        s1 = tap(taps, TAP_S1);
        w1 = tap(taps, TAP_W1);
        e1 = tap(taps, TAP_E1);
        n2 = tap(taps, TAP_N2);
        s2 = tap(taps, TAP_S2);
        w2 = tap(taps, TAP_W2);
        e2 = tap(taps, TAP_E2);
        nw = tap(taps, TAP_NW);
        ne = tap(taps, TAP_NE);
        sw = tap(taps, TAP_SW);
        se = tap(taps, TAP_SE);
    end

    // Kernel sums with doubled coefficients
    always_comb
    begin
        g_rb_sum  = SW'(8 * c + 4 * (n1 + s1 + w1 + e1) - 2 * (n2 + s2 + w2 + e2));
        horiz_sum = SW'(10 * c + 8 * (w1 + e1) - 2 * (w2 + e2)
                        - 2 * (nw + ne + sw + se) + (n2 + s2));
        vert_sum  = SW'(10 * c + 8 * (n1 + s1) - 2 * (n2 + s2)
                        - 2 * (nw + ne + sw + se) + (w2 + e2));
        diag_sum  = SW'(12 * c + 4 * (nw + ne + sw + se) - 3 * (n2 + s2 + w2 + e2));
    end

    // Register the sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            g_rb_reg   <= g_rb_sum;
            horiz_reg  <= horiz_sum;
            vert_reg   <= vert_sum;
            diag_reg   <= diag_sum;
            centre_reg <= taps[TAP_C*PIXEL_BITS +: PIXEL_BITS];
            tag_reg    <= tag;
        end
    end

    // Scale and select colours by site parity
    always_comb
    begin
        g_rb_px  = finish(g_rb_reg);
        horiz_px = finish(horiz_reg);
        vert_px  = finish(vert_reg);
        diag_px  = finish(diag_reg);

        if (!tag_reg.odd_row && !tag_reg.odd_col)
        begin
            red   = centre_reg;
            green = g_rb_px;
            blue  = diag_px;
        end
        else if (tag_reg.odd_row && tag_reg.odd_col)
        begin
            red   = diag_px;
            green = g_rb_px;
            blue  = centre_reg;
        end
        else if (!tag_reg.odd_row)
        begin
            red   = horiz_px;
            green = centre_reg;
            blue  = vert_px;
        end
        else
        begin
            red   = vert_px;
            green = centre_reg;
            blue  = horiz_px;
        end
    end

    assign res_valid    = a_valid_reg;
    assign end_of_row   = tag_reg.end_of_row;
    assign end_of_frame = tag_reg.end_of_frame;
    assign busy         = a_valid_reg;

endmodule

[rtl/bayer_demosaic_5x5.sv]
// Top level of the streaming 5x5 Bayer demosaic.
//
// Input queue side: raw samples of an RGGB frame, padded by two samples on
// every side, arrive in raster order; a request is taken when push is high
// and full is low. Output queue side: one RGB pixel per interior position,
// present while empty is low and taken when pop is high.
// Configuration: cfg_we with cfg_index 0 (image_width) or 1 (image_height)
// writes a size and restarts the frame position; write only while idle.
// Throughput: one sample per clock while full is low. Border samples give no pixel.
// After the edge that takes its sample, a pixel passes the window shift, the
// handoff queue, the kernel sum and the output queue to the output ports.
// A front end (counters, four line stores, window) and a back end (kernel
// arithmetic) are parted by an eight-entry queue; a four-entry queue holds
// finished pixels. When pop stays low the queues fill and full rises; no
// request is lost. Reset empties both queues, zeroes the frame position and
// sets the size to 640x480; line stores are not cleared and need no pass.
`include "bayer_demosaic_5x5_defines.svh"

module bayer_demosaic_5x5 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bdm_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [PIXEL_BITS-1:0]              raw_pixel,
    output logic                               empty,
    input  logic                               pop,
    output logic [PIXEL_BITS-1:0]              red,
    output logic [PIXEL_BITS-1:0]              green,
    output logic [PIXEL_BITS-1:0]              blue,
    output logic                               end_of_row,
    output logic                               end_of_frame
);

    import bdm_pkg::*;

    localparam int TAPS_W = NUM_TAPS * PIXEL_BITS;
    localparam int MID_W  = TAPS_W + $bits(bdm_tag_t);
    localparam int OUT_W  = 3 * PIXEL_BITS + 2;
    localparam int MID_CW = $clog2(MID_DEPTH + 1);
    localparam int MID_LW = MID_CW + 1;
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam int OUT_LW = OUT_CW + 1;

    logic                  accept;
    logic                  task_valid;
    logic [TAPS_W-1:0]     task_taps;
    bdm_tag_t              task_tag;
    logic [1:0]            front_inflight;

    logic [MID_W-1:0]      mid_rdata;
    logic                  mid_empty;
    logic [MID_CW-1:0]     mid_count;
    logic                  mid_pop;
    logic [TAPS_W-1:0]     mid_taps;
    bdm_tag_t              mid_tag;
    logic [MID_LW-1:0]     mid_load;

    logic                  res_valid;
    logic [PIXEL_BITS-1:0] res_red, res_green, res_blue;
    logic                  res_eor, res_eof;
    logic                  back_busy;

    logic [OUT_W-1:0]      out_rdata;
    logic [OUT_CW-1:0]     out_count;
    logic [OUT_LW-1:0]     out_load;
    logic                  out_pop;

    // Reserve queue room for requests still in the front pipeline
    assign mid_load = MID_LW'(mid_count) + MID_LW'(front_inflight);
    assign full     = (mid_load >= MID_LW'(MID_DEPTH));
    assign accept   = push && !full;

    bdm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .raw_pixel  (raw_pixel),
        .task_valid (task_valid),
        .task_taps  (task_taps),
        .task_tag   (task_tag),
        .in_flight  (front_inflight)
    );

    bdm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (task_valid),
        .wdata ({task_tag, task_taps}),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign {mid_tag, mid_taps} = mid_rdata;

    // Drain into the back end only with room left in the output queue
    assign out_load = OUT_LW'(out_count) + OUT_LW'(back_busy);
    assign mid_pop  = !mid_empty && (out_load < OUT_LW'(OUT_DEPTH));

    bdm_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (mid_pop),
        .taps         (mid_taps),
        .tag          (mid_tag),
        .res_valid    (res_valid),
        .red          (res_red),
        .green        (res_green),
        .blue         (res_blue),
        .end_of_row   (res_eor),
        .end_of_frame (res_eof),
        .busy         (back_busy)
    );

    assign out_pop = pop && !empty;

    bdm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata ({res_red, res_green, res_blue, res_eor, res_eof}),
        .pop   (out_pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign {red, green, blue, end_of_row, end_of_frame} = out_rdata;

    `BDM_ASSERT(a_mid_credit, mid_load <= MID_LW'(MID_DEPTH), "handoff queue overcommitted")
    `BDM_ASSERT(a_out_credit, out_load <= OUT_LW'(OUT_DEPTH), "output queue overcommitted")
    `BDM_ASSERT(a_eof_on_eor, empty || !end_of_frame || end_of_row, "frame end off a row end")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the streaming 5x5 Bayer demosaic block.
`timescale 1ns / 1ps

module testbench;
    import bdm_pkg::*;

    localparam int MAX_WIDTH      = 2048;
    localparam int PIXEL_BITS     = 8;
    localparam int LINE_LEN       = MAX_WIDTH + 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 3000;
    localparam int RANDOM_SAMPLES = 800;
    localparam int REPORT_LIMIT   = 10;

    // Register indexes that select nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic                  row_end;
        logic                  frame_end;
    } pixel_rgb_t;

    typedef enum logic {DIR_CFG, DIR_PIX} dir_op_t;

    typedef enum int {CONTENT_NOISE, CONTENT_EXTREME, CONTENT_SMOOTH} content_t;

    typedef struct packed {
        dir_op_t                 op;
        logic [CFG_INDEX_BITS-1:0] reg_sel;
        logic [CFG_BITS-1:0]     value;
        logic                    fixed;
        pixel_rgb_t              want;
    } dir_row_t;

    // Smallest frame: 5x5 padded samples around one red site. The inner ring
    // is full scale and the center and outer cross are zero, so green and
    // blue both saturate high while red stays at zero.
    localparam dir_row_t DIRECTED [28] = '{
        '{DIR_CFG, REG_IMAGE_WIDTH,  12'd0,   1'b0, '0},
        '{DIR_CFG, REG_IMAGE_HEIGHT, 12'd0,   1'b0, '0},
        '{DIR_CFG, REG_SPARE_LO,     12'hFFF, 1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'h00,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'h00,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'h00,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'h00,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'h00,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b0, '0},
        '{DIR_PIX, REG_IMAGE_WIDTH,  12'hFF,  1'b1,
          '{8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1}}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic [PIXEL_BITS-1:0]     raw_pixel = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [PIXEL_BITS-1:0]     red;
    logic [PIXEL_BITS-1:0]     green;
    logic [PIXEL_BITS-1:0]     blue;
    logic                      end_of_row;
    logic                      end_of_frame;

    // Demosaic state tracked on the testbench side
    logic [PIXEL_BITS-1:0] line_mem [LINE_BANKS][LINE_LEN];
    logic [PIXEL_BITS-1:0] win [WIN_SIZE][WIN_SIZE];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;

    pixel_rgb_t pending_pixels [$];
    pixel_rgb_t rx_want;

    int  mismatches = 0;
    int  pixels_checked = 0;
    int  frame_ends = 0;
    int  samples_sent = 0;
    int  random_sent = 0;
    int  stall_count = 0;
    int  hold_reqs = 0;
    int  holds_served = 0;
    int  rx_hold_left = 0;
    int  rx_gap = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  calm = 1'b0;
    int  smooth_base = 128;

    bayer_demosaic_5x5 #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .raw_pixel   (raw_pixel),
        .empty       (empty),
        .pop         (pop),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .end_of_row  (end_of_row),
        .end_of_frame(end_of_frame)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_width(logic [CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_height(logic [CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_HEIGHT)
            return MAX_HEIGHT;
        return 32'(v);
    endfunction

    function automatic int unsigned frame_samples();
        return (eff_width(width_reg) + 4) * (eff_height(height_reg) + 4);
    endfunction

    function automatic void reset_model();
        width_reg  = CFG_BITS'(WIDTH_RESET);
        height_reg = CFG_BITS'(HEIGHT_RESET);
        for (int b = 0; b < LINE_BANKS; b++)
            for (int x = 0; x < LINE_LEN; x++)
                line_mem[b][x] = '0;
        for (int y = 0; y < WIN_SIZE; y++)
            for (int x = 0; x < WIN_SIZE; x++)
                win[y][x] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Any write to a real register restarts the frame position
    function automatic void apply_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = v;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = v;
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic int tap(int dy, int dx);
        return int'(win[dy + 2][dx + 2]);
    endfunction

    // Divide by 16 rounding down, then clamp to the pixel range
    function automatic logic [PIXEL_BITS-1:0] saturate(int sum);
        int q;
        q = sum >>> 4;
        if (q < 0)
            return '0;
        if (q > (1 << PIXEL_BITS) - 1)
            return '1;
        return q[PIXEL_BITS-1:0];
    endfunction

    function automatic logic [PIXEL_BITS-1:0] cross_green();
        return saturate(8 * tap(0, 0)
                        + 4 * (tap(-1, 0) + tap(1, 0) + tap(0, -1) + tap(0, 1))
                        - 2 * (tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2)));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] row_pair_at_green();
        return saturate(10 * tap(0, 0)
                        + 8 * (tap(0, -1) + tap(0, 1))
                        - 2 * (tap(0, -2) + tap(0, 2))
                        - 2 * (tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1))
                        + (tap(-2, 0) + tap(2, 0)));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] col_pair_at_green();
        return saturate(10 * tap(0, 0)
                        + 8 * (tap(-1, 0) + tap(1, 0))
                        - 2 * (tap(-2, 0) + tap(2, 0))
                        - 2 * (tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1))
                        + (tap(0, -2) + tap(0, 2)));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] diagonal_at_rb();
        return saturate(12 * tap(0, 0)
                        + 4 * (tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1))
                        - 3 * (tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2)));
    endfunction

    // Advance the line stores and window by one sample; return 1 with the
    // interpolated pixel when the sample completes an interior window
    function automatic bit demosaic_sample(input logic [PIXEL_BITS-1:0] sample,
                                           output pixel_rgb_t px);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        int unsigned           r;
        logic [PIXEL_BITS-1:0] column [WIN_SIZE];
        bit                    made;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        c = col_pos;
        r = row_pos;
        if (c >= w + 4)
            c = 0;
        if (r >= h + 4)
            r = 0;
        for (int k = 0; k < LINE_BANKS; k++)
            column[k] = line_mem[(r + k) % LINE_BANKS][c];
        column[WIN_SIZE-1] = sample;
        line_mem[r % LINE_BANKS][c] = sample;
        for (int y = 0; y < WIN_SIZE; y++)
        begin
            for (int x = 0; x < WIN_SIZE - 1; x++)
                win[y][x] = win[y][x + 1];
            win[y][WIN_SIZE-1] = column[y];
        end
        made = (r >= 4) && (c >= 4);
        px = '0;
        if (made)
        begin
            // Site color from padded row and column parity
            case ({r[0], c[0]})
                2'b00:
                begin
                    px.red   = win[2][2];
                    px.green = cross_green();
                    px.blue  = diagonal_at_rb();
                end
                2'b11:
                begin
                    px.blue  = win[2][2];
                    px.green = cross_green();
                    px.red   = diagonal_at_rb();
                end
                2'b01:
                begin
                    px.green = win[2][2];
                    px.red   = row_pair_at_green();
                    px.blue  = col_pair_at_green();
                end
                default:
                begin
                    px.green = win[2][2];
                    px.blue  = row_pair_at_green();
                    px.red   = col_pair_at_green();
                end
            endcase
            px.row_end   = (c == w + 3);
            px.frame_end = (c == w + 3) && (r == h + 3);
        end
        c++;
        if (c >= w + 4)
        begin
            c = 0;
            r++;
            if (r >= h + 4)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
        return made;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_sample(content_t mode);
        int v;
        case (mode)
            CONTENT_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            CONTENT_SMOOTH:
            begin
                v = smooth_base + int'($urandom_range(0, 24)) - 12;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return v[PIXEL_BITS-1:0];
            end
            default: return PIXEL_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one sample request, with an occasional gap first, and predict
    // its pixel once it is taken
    task automatic offer_sample(input logic [PIXEL_BITS-1:0] sample, input bit fixed,
                                input pixel_rgb_t fixed_px);
        pixel_rgb_t px;
        bit         made;
        if (tx_idle_on && !calm && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push      <= 1'b1;
        raw_pixel <= sample;
        do
            @(posedge clk);
        while (full);
        made = demosaic_sample(sample, px);
        if (made)
            pending_pixels = {pending_pixels, (fixed ? fixed_px : px)};
        samples_sent++;
    endtask

    task automatic send_run(input content_t mode, input int unsigned count);
        smooth_base = $urandom_range(12, 243);
        for (int unsigned i = 0; i < count; i++)
            offer_sample(pick_sample(mode), 1'b0, '0);
    endtask

    // Stop offering, wait for every pixel, then let border samples clear
    task automatic drain_block();
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        apply_cfg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase();
        int unsigned    kind;
        int unsigned    flen;
        int unsigned    count;
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
        drain_block();
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = CFG_BITS'($urandom_range(13, 40));
            default: w = CFG_BITS'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       h = '0;
            1:       h = CFG_BITS'($urandom_range(7, 12));
            default: h = CFG_BITS'($urandom_range(1, 6));
        endcase
        // New size (one or both registers), spare write, or carry on mid-frame
        if (kind < 6)
        begin
            if (kind != 5)
                cfg_write(REG_IMAGE_WIDTH, w);
            if (kind != 4)
                cfg_write(REG_IMAGE_HEIGHT, h);
        end
        else if (kind < 8)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_BITS'($urandom_range(0, 4095)));
        flen = frame_samples();
        if ($urandom_range(0, 4) == 0)
            count = $urandom_range(1, 2 * flen);
        else
            count = flen * $urandom_range(1, 2);
        // Stop at the random budget, mid-frame if need be
        if (count > unsigned'(RANDOM_SAMPLES - random_sent))
            count = unsigned'(RANDOM_SAMPLES - random_sent);
        send_run(content_t'($urandom_range(0, 2)), count);
        random_sent += int'(count);
    endtask

    // Check each pixel request against the oldest prediction and pace pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                             $realtime, red, green, blue, end_of_row, end_of_frame);
            end
            else
            begin
                rx_want = pending_pixels.pop_front();
                if (red !== rx_want.red || green !== rx_want.green ||
                    blue !== rx_want.blue || end_of_row !== rx_want.row_end ||
                    end_of_frame !== rx_want.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                                 $realtime, pixels_checked, rx_want.red, rx_want.green,
                                 rx_want.blue, rx_want.row_end, rx_want.frame_end);
                        $display("    got r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                                 red, green, blue, end_of_row, end_of_frame);
                    end
                end
                if (rx_want.frame_end)
                    frame_ends++;
                pixels_checked++;
            end
        end
        // Long hold on request, else random stall bursts
        if (holds_served != hold_reqs)
        begin
            holds_served = hold_reqs;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            pop <= 1'b0;
        end
        else if (rx_idle_on && !calm && $urandom_range(0, 9) == 0)
        begin
            rx_gap = int'($urandom_range(1, 17)) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // End the run if no request moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset height: a one-wide frame runs twelve padded rows with no wrap
        cfg_write(REG_IMAGE_WIDTH, 12'd1);
        send_run(CONTENT_NOISE, 5 * 12);
        drain_block();

        // Directed frame and register writes
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].op == DIR_CFG)
                cfg_write(DIRECTED[i].reg_sel, DIRECTED[i].value);
            else
                offer_sample(DIRECTED[i].value[PIXEL_BITS-1:0], DIRECTED[i].fixed,
                             DIRECTED[i].want);
        end
        drain_block();

        // Hold the output side long enough for the block to back up
        cfg_write(REG_IMAGE_WIDTH, 12'd16);
        cfg_write(REG_IMAGE_HEIGHT, 12'd8);
        hold_reqs++;
        send_run(CONTENT_NOISE, frame_samples());
        drain_block();

        // Random sizes, content and framing
        while (random_sent < RANDOM_SAMPLES)
            random_phase();

        // Final stretch with both sides streaming at full rate
        drain_block();
        calm = 1'b1;
        cfg_write(REG_IMAGE_WIDTH, 12'd9);
        cfg_write(REG_IMAGE_HEIGHT, 12'd5);
        send_run(CONTENT_NOISE, 2 * frame_samples());
        drain_block();

        $display("Covered %0d raw samples, %0d pixels checked, %0d frame ends,",
                 samples_sent, pixels_checked, frame_ends);
        $display("sizes from clamped 1x1 up to 40x12, mid-frame restarts, stalls on both sides.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bdm_pkg.sv
rtl/bdm_fifo.sv
rtl/bdm_front.sv
rtl/bdm_back.sv
rtl/bayer_demosaic_5x5.sv
dv/testbench.sv
